// ===== src/mbet_pkg.sv =====
// Package for the escape-time pixel block: fixed-point formats, constants,
// register indexes and the word types passed between the iteration cells.
// No dependencies.
package mbet_pkg;

  // z components carry ZFRAC fraction bits and are held within +-8.0.
  localparam int ZFRAC = 26;
  localparam int ZW    = 31;
  localparam int PW    = 2 * ZW;
  localparam int ZCLAMP = 2 ** (ZFRAC + 3);

  localparam int CNT_W      = 8;
  localparam int THR_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_THR  = 1'b1;

  localparam logic [CNT_W-1:0] MAX_ITER_RST = 8'd255;
  localparam logic [THR_W-1:0] ESC_THR_RST  = 5'd10;

  // A point in flight: current z and the number of updates done so far.
  typedef struct packed {
    logic                   vld;
    logic signed [ZW-1:0]   x;
    logic signed [ZW-1:0]   y;
    logic [CNT_W-1:0]       k;
  } mbet_tok_t;

  // Products of one z, registered between the two halves of a cell.
  typedef struct packed {
    logic                   vld;
    logic signed [PW-1:0]   xx;
    logic signed [PW-1:0]   yy;
    logic signed [PW-1:0]   xy;
    logic [CNT_W-1:0]       k;
  } mbet_prod_t;

  // Finish report from a cell.
  typedef struct packed {
    logic               vld;
    logic [CNT_W-1:0]   cnt;
  } mbet_fin_t;

endpackage

// ===== src/mbet_if.sv =====
// Valid/ready channel interfaces for the point input and the pixel output.
// Depends on nothing.
interface mbet_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] c_real;
  logic signed [31:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbet_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] iteration_count;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output iteration_count, output red, output green,
                  output blue, input ready);
  modport sink   (input valid, input iteration_count, input red, input green,
                  input blue, output ready);
endinterface

// ===== src/mandelbrot_escape_time_pixel_top.sv =====
// Top level of the escape-time pixel block: ring of iteration cells, config
// registers and output register. Depends on mbet_pkg, mbet_if and mbet_cell.
// Flow: a taken point passes, for each update, the product register and then
// the token register of a cell; a finish report goes to the output register.
// One point at a time: a new word is taken only after the last one has left
// the ring. Each update in a cell squares z, then adds c.
// Reset (synchronous, active low) empties the ring and the output register and
// loads max_iterations = 255 and escape_threshold = 10.
module mandelbrot_escape_time_pixel_top #(
  parameter int FRAC_BITS = 28,
  parameter int NUM_CELLS = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mbet_in_if.sink                           in_chan,
  mbet_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mbet_pkg::*;

  // The input is brought from FRAC_BITS to ZFRAC fraction bits. A left shift
  // is exact; a right shift floors, which is what an arithmetic shift does.
  localparam int LSH  = (FRAC_BITS < ZFRAC) ? (ZFRAC - FRAC_BITS) : 0;
  localparam int RSH  = (FRAC_BITS > ZFRAC) ? (FRAC_BITS - ZFRAC) : 0;
  localparam int CZ_W = 32 + LSH;

  logic [CNT_W-1:0] max_iter_r;
  logic [THR_W-1:0] esc_thr_r;

  logic                   busy_r;
  logic signed [CZ_W-1:0] cr_r;
  logic signed [CZ_W-1:0] ci_r;
  logic signed [CZ_W-1:0] cr_ext;
  logic signed [CZ_W-1:0] ci_ext;
  logic signed [CZ_W-1:0] cr_nxt;
  logic signed [CZ_W-1:0] ci_nxt;

  logic             out_vld_r;
  logic [CNT_W-1:0] cnt_r;
  logic [2*CNT_W-1:0] cnt_sq;

  logic in_acc;
  logic adv;
  logic fin_any;
  logic [CNT_W-1:0] fin_cnt;
  logic [NUM_CELLS-1:0] tok_vld;
  logic [NUM_CELLS-1:0] fin_vld;

  mbet_tok_t tok [NUM_CELLS+1];
  mbet_tok_t tok_new;
  mbet_fin_t fin_w [NUM_CELLS];

  // Configuration writes. The port is a single-bit index, so both codes are
  // registers; a value wider than a register keeps only its low bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
      esc_thr_r  <= ESC_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_ITER: max_iter_r <= cfg_wdata[CNT_W-1:0];
        CFG_ESC_THR:  esc_thr_r  <= cfg_wdata[THR_W-1:0];
        default:      ;
      endcase
    end
  end

  // Only one point is in the ring at a time; a new word is taken once the
  // previous result has been moved into the output register.
  assign in_chan.ready = !busy_r;
  assign in_acc        = in_chan.valid && !busy_r;

  always_comb begin
    cr_ext = CZ_W'(in_chan.c_real);
    ci_ext = CZ_W'(in_chan.c_imag);
    cr_nxt = (cr_ext <<< LSH) >>> RSH;
    ci_nxt = (ci_ext <<< LSH) >>> RSH;
  end

  // c stays put in these registers and is broadcast to every cell.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cr_r <= cr_nxt;
      ci_r <= ci_nxt;
    end
  end

  // A fresh point starts at z = 0 with no updates done. It enters the first
  // cell in place of whatever would wrap around from the last one, which is
  // nothing since the ring is empty while the block is not busy.
  always_comb begin
    tok_new.vld = 1'b1;
    tok_new.x   = '0;
    tok_new.y   = '0;
    tok_new.k   = '0;
    tok[0]      = in_acc ? tok_new : tok[NUM_CELLS];
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    mbet_cell #(
      .C_W (CZ_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .max_iter (max_iter_r),
      .esc_thr  (esc_thr_r),
      .c_re     (cr_r),
      .c_im     (ci_r),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .fin      (fin_w[i])
    );
    assign tok_vld[i] = tok[i+1].vld;
    assign fin_vld[i] = fin_w[i].vld;
  end

  // At most one cell reports a finish, so the counts can be merged by OR.
  always_comb begin
    fin_any = 1'b0;
    fin_cnt = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (fin_w[i].vld) begin
        fin_any = 1'b1;
        fin_cnt = fin_cnt | fin_w[i].cnt;
      end
    end
  end

  // The ring freezes only when a point is done and the output register still
  // holds a result the sink has not taken.
  assign adv = !(fin_any && out_vld_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
    end else if (fin_any && adv) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fin_any && adv) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_any && adv) begin
      cnt_r <= fin_cnt;
    end
  end

  // Colour: red and blue follow the count, green is the count squared mod 256.
  assign cnt_sq                   = cnt_r * cnt_r;
  assign out_chan.valid           = out_vld_r;
  assign out_chan.iteration_count = cnt_r;
  assign out_chan.red             = cnt_r;
  assign out_chan.green           = cnt_sq[CNT_W-1:0];
  assign out_chan.blue            = cnt_r;

`ifndef SYNTHESIS
  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_vld, fin_vld}))
    else $error("more than one point in the iteration ring");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (tok_vld == '0) && (fin_vld == '0))
    else $error("iteration ring holds a point while idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fin_any |-> fin_cnt <= max_iter_r)
    else $error("finish count beyond the iteration limit");

  a_out_from_ring: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $fell(busy_r))
    else $error("result appeared without a point leaving the ring");
`endif

endmodule

// ===== src/mbet_cell.sv =====
// One iteration cell: squares z in its first half and forms z*z + c, the
// escape test and the finish report in its second half. Depends on mbet_pkg.
module mbet_cell #(
  parameter int C_W = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [mbet_pkg::CNT_W-1:0]   max_iter,
  input  logic [mbet_pkg::THR_W-1:0]   esc_thr,
  input  logic signed [C_W-1:0]        c_re,
  input  logic signed [C_W-1:0]        c_im,
  input  mbet_pkg::mbet_tok_t          tok_in,
  output mbet_pkg::mbet_tok_t          tok_out,
  output mbet_pkg::mbet_fin_t          fin
);
  import mbet_pkg::*;

  // Wide enough for c and for the rescaled products before saturation.
  localparam int SUM_W = ((C_W > 38) ? C_W : 38) + 1;
  localparam logic signed [SUM_W-1:0] ZMAX = SUM_W'(ZCLAMP);
  localparam logic signed [SUM_W-1:0] ZMIN = -ZMAX;

  mbet_prod_t prod_r, prod_nxt;
  mbet_tok_t  tok_r, tok_nxt;

  logic [PW-1:0]           mag;
  logic [PW-1:0]           lim;
  logic                    escaped;
  logic                    at_limit;
  logic signed [PW:0]      diff;
  logic signed [PW:0]      re_sh;
  logic signed [PW-1:0]    im_sh;
  logic signed [SUM_W-1:0] re_sum;
  logic signed [SUM_W-1:0] im_sum;
  logic signed [SUM_W-1:0] re_sat;
  logic signed [SUM_W-1:0] im_sat;

  always_comb begin
    prod_nxt.vld = tok_in.vld;
    prod_nxt.xx  = tok_in.x * tok_in.x;
    prod_nxt.yy  = tok_in.y * tok_in.y;
    prod_nxt.xy  = tok_in.x * tok_in.y;
    prod_nxt.k   = tok_in.k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.vld <= 1'b0;
    end else if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    // The squares belong to the z reached after prod_r.k updates.
    mag      = $unsigned(prod_r.xx) + $unsigned(prod_r.yy);
    lim      = PW'(esc_thr) << (2 * ZFRAC);
    escaped  = mag > lim;
    at_limit = prod_r.k == max_iter;

    diff   = prod_r.xx - prod_r.yy;
    re_sh  = diff >>> ZFRAC;
    im_sh  = prod_r.xy >>> (ZFRAC - 1);
    re_sum = $signed(re_sh[SUM_W-1:0]) + SUM_W'(c_re);
    im_sum = $signed(im_sh[SUM_W-1:0]) + SUM_W'(c_im);

    if (re_sum > ZMAX) begin
      re_sat = ZMAX;
    end else if (re_sum < ZMIN) begin
      re_sat = ZMIN;
    end else begin
      re_sat = re_sum;
    end
    if (im_sum > ZMAX) begin
      im_sat = ZMAX;
    end else if (im_sum < ZMIN) begin
      im_sat = ZMIN;
    end else begin
      im_sat = im_sum;
    end

    tok_nxt.vld = prod_r.vld && !escaped && !at_limit;
    tok_nxt.x   = re_sat[ZW-1:0];
    tok_nxt.y   = im_sat[ZW-1:0];
    tok_nxt.k   = prod_r.k + CNT_W'(1);

    fin.vld = prod_r.vld && (escaped || at_limit);
    fin.cnt = escaped ? (prod_r.k - CNT_W'(1)) : prod_r.k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
